/* rtl/tsph_pkg.sv */
// Shared types and constants for the transport stream packet header parser.
// Used by the result queue and the parser top level; no dependencies.
package tsph_pkg;

    localparam int PACKET_BYTES_DEFAULT = 188;
    localparam int QUEUE_DEPTH_DEFAULT  = 4;

    localparam int INDEX_W   = 8;
    localparam int PCR_W     = 42;
    localparam int PCR_RAW_W = 48;

    localparam logic [INDEX_W-1:0] HEADER_BYTES = 8'd4;
    localparam logic [INDEX_W-1:0] ADAPT_LEN_IDX = 8'd4;
    localparam logic [INDEX_W-1:0] ADAPT_FLAG_IDX = 8'd5;
    localparam logic [INDEX_W-1:0] PCR_FIRST_IDX = 8'd6;
    localparam logic [INDEX_W-1:0] PCR_LAST_IDX = 8'd11;

    localparam int PCR_FLAG_BIT = 4;
    localparam int PCR_SCALE    = 300;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_OVERRUN = 2'd1;
    localparam logic [1:0] STATUS_SHORT   = 2'd2;

    typedef struct packed {
        logic             result_kind;
        logic [7:0]       payload_byte;
        logic [2:0]       header_flags;
        logic [12:0]      packet_id;
        logic [1:0]       scrambling;
        logic [1:0]       adapt_control;
        logic [3:0]       continuity;
        logic [7:0]       adapt_flags;
        logic [PCR_W-1:0] clock_reference;
        logic [7:0]       payload_length;
        logic [1:0]       status;
    } result_t;

    // Up to two results enter the queue per accepted byte, in order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

/* rtl/ts_packet_header_parser_core.sv */
// Transport stream packet header parser: byte-wise header, adaptation and PCR
// unpacking with payload pass-through. Depends on tsph_pkg and tsph_result_queue.
// Latency: results of a byte are written at its accept edge and can be taken
// from the next cycle on. Throughput: one byte per cycle while the queue has room
// for two results, set by the per-byte update of the parse state registers and a
// default four-entry result queue that absorbs bytes yielding two results.
// Reset clears the parse state and empties the queue; there is no clearing pass.
module ts_packet_header_parser_core #(
    parameter int PACKET_BYTES = tsph_pkg::PACKET_BYTES_DEFAULT,
    parameter int QUEUE_DEPTH  = tsph_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 data_byte,
    input  logic                       packet_start,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       result_kind,
    output logic [7:0]                 payload_byte,
    output logic [2:0]                 header_flags,
    output logic [12:0]                packet_id,
    output logic [1:0]                 scrambling,
    output logic [1:0]                 adapt_control,
    output logic [3:0]                 continuity,
    output logic [7:0]                 adapt_flags,
    output logic [tsph_pkg::PCR_W-1:0] clock_reference,
    output logic [7:0]                 payload_length,
    output logic [1:0]                 status
);

    localparam int IW = tsph_pkg::INDEX_W;
    localparam logic [IW-1:0] LAST_COUNT = IW'(PACKET_BYTES);
    localparam logic [7:0]    MAX_ADAPT  = 8'(PACKET_BYTES - 5);

    // Parse state. Only the low 24 header bits carry fields; the sync byte drops out.
    logic [IW-1:0]                     byte_index_reg, byte_index_next;
    logic                              in_packet_reg, in_packet_next;
    logic [23:0]                       header_reg, header_next;
    logic [7:0]                        adapt_length_reg, adapt_length_next;
    logic [7:0]                        adapt_flag_reg, adapt_flag_next;
    logic [tsph_pkg::PCR_RAW_W-1:0]    pcr_shift_reg, pcr_shift_next;
    logic [7:0]                        payload_count_reg, payload_count_next;
    logic [1:0]                        error_code_reg, error_code_next;
    logic [tsph_pkg::PCR_W-1:0]        pcr_value_reg;

    logic                              accept;
    logic                              active;
    logic                              early_end;
    logic                              emit_payload;
    logic                              emit_end;
    logic                              pcr_valid;
    logic [IW-1:0]                     idx;
    logic [IW-1:0]                     idx_next;
    logic [23:0]                       hw;
    logic [7:0]                        al;
    logic [7:0]                        afr;
    logic [tsph_pkg::PCR_RAW_W-1:0]    ps;
    logic [7:0]                        pc;
    logic [1:0]                        err;
    logic [8:0]                        first_payload;
    tsph_pkg::result_t                 early_item;
    tsph_pkg::result_t                 payload_item;
    tsph_pkg::result_t                 end_item;
    tsph_pkg::push_t                   push;
    tsph_pkg::result_t                 head;
    logic                              room_for_two;

    function automatic tsph_pkg::result_t make_summary(
        input logic [23:0]                h,
        input logic [7:0]                 flags,
        input logic [tsph_pkg::PCR_W-1:0] pcr,
        input logic [7:0]                 count,
        input logic [1:0]                 code
    );
        tsph_pkg::result_t r;
        r.result_kind     = tsph_pkg::KIND_SUMMARY;
        r.payload_byte    = 8'd0;
        r.header_flags    = h[23:21];
        r.packet_id       = h[20:8];
        r.scrambling      = h[7:6];
        r.adapt_control   = h[5:4];
        r.continuity      = h[3:0];
        r.adapt_flags     = (code == tsph_pkg::STATUS_OVERRUN) ? 8'd0 : flags;
        r.clock_reference = pcr;
        r.payload_length  = count;
        r.status          = code;
        return r;
    endfunction

    assign in_ready = room_for_two;
    assign accept   = in_valid & in_ready;

    always_comb
    begin
        active    = in_packet_reg | packet_start;
        early_end = packet_start & in_packet_reg & (byte_index_reg < LAST_COUNT);

        // A start byte sees a freshly cleared packet.
        idx = packet_start ? '0 : byte_index_reg;
        hw  = packet_start ? '0 : header_reg;
        al  = packet_start ? '0 : adapt_length_reg;
        afr = packet_start ? '0 : adapt_flag_reg;
        ps  = packet_start ? '0 : pcr_shift_reg;
        pc  = packet_start ? '0 : payload_count_reg;
        err = packet_start ? tsph_pkg::STATUS_OK : error_code_reg;

        header_next        = hw;
        adapt_length_next  = al;
        adapt_flag_next    = afr;
        pcr_shift_next     = ps;
        payload_count_next = pc;
        error_code_next    = err;
        emit_payload       = 1'b0;
        first_payload      = 9'd4;

        if (idx < tsph_pkg::HEADER_BYTES)
        begin
            header_next = {hw[15:0], data_byte};
        end
        else
        begin
            if (hw[5] && idx == tsph_pkg::ADAPT_LEN_IDX)
            begin
                adapt_length_next = data_byte;
                if (data_byte > MAX_ADAPT)
                begin
                    error_code_next = tsph_pkg::STATUS_OVERRUN;
                end
            end
            else if (hw[5] && idx == tsph_pkg::ADAPT_FLAG_IDX && al != 8'd0
                     && err == tsph_pkg::STATUS_OK)
            begin
                adapt_flag_next = data_byte;
            end

            // The PCR bytes are collected even when the field is shorter than them.
            if (hw[5] && err == tsph_pkg::STATUS_OK && al != 8'd0
                && afr[tsph_pkg::PCR_FLAG_BIT]
                && idx >= tsph_pkg::PCR_FIRST_IDX && idx <= tsph_pkg::PCR_LAST_IDX)
            begin
                pcr_shift_next = {ps[tsph_pkg::PCR_RAW_W-9:0], data_byte};
            end

            first_payload = hw[5] ? (9'd5 + {1'b0, adapt_length_next}) : 9'd4;
            if (hw[4] && error_code_next == tsph_pkg::STATUS_OK
                && {1'b0, idx} >= first_payload)
            begin
                emit_payload       = active;
                payload_count_next = pc + 8'd1;
            end
        end

        idx_next = idx + IW'(1);
        emit_end = active & (idx_next >= LAST_COUNT);

        byte_index_next = byte_index_reg;
        in_packet_next  = in_packet_reg;
        if (active)
        begin
            byte_index_next = idx_next;
            in_packet_next  = ~emit_end;
        end

        pcr_valid = (error_code_next == tsph_pkg::STATUS_OK) & hw[5]
                    & (adapt_length_next != 8'd0)
                    & adapt_flag_next[tsph_pkg::PCR_FLAG_BIT];

        early_item = make_summary(header_reg, adapt_flag_reg, '0, payload_count_reg,
                                  tsph_pkg::STATUS_SHORT);
        end_item   = make_summary(header_next, adapt_flag_next,
                                  pcr_valid ? pcr_value_reg : '0,
                                  payload_count_next, error_code_next);

        payload_item              = '0;
        payload_item.result_kind  = tsph_pkg::KIND_PAYLOAD;
        payload_item.payload_byte = data_byte;

        push.count  = accept ? (2'(early_end) + 2'(emit_payload) + 2'(emit_end)) : 2'd0;
        push.first  = early_end ? early_item : (emit_payload ? payload_item : end_item);
        push.second = end_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg    <= '0;
            in_packet_reg     <= 1'b0;
            header_reg        <= '0;
            adapt_length_reg  <= '0;
            adapt_flag_reg    <= '0;
            pcr_shift_reg     <= '0;
            payload_count_reg <= '0;
            error_code_reg    <= tsph_pkg::STATUS_OK;
        end
        else if (accept && active)
        begin
            byte_index_reg    <= byte_index_next;
            in_packet_reg     <= in_packet_next;
            header_reg        <= header_next;
            adapt_length_reg  <= adapt_length_next;
            adapt_flag_reg    <= adapt_flag_next;
            pcr_shift_reg     <= pcr_shift_next;
            payload_count_reg <= payload_count_next;
            error_code_reg    <= error_code_next;
        end
    end

    // PCR = 300 * base + extension. The raw word settles at byte 11, long before
    // the packet's last byte, so a registered product is always current there.
    always_ff @(posedge clk)
    begin
        pcr_value_reg <= tsph_pkg::PCR_W'({9'd0, pcr_shift_reg[47:15]}
                                          * tsph_pkg::PCR_W'(tsph_pkg::PCR_SCALE))
                         + tsph_pkg::PCR_W'(pcr_shift_reg[8:0]);
    end

    tsph_result_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room_for_two (room_for_two),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .head         (head)
    );

    assign result_kind     = head.result_kind;
    assign payload_byte    = head.payload_byte;
    assign header_flags    = head.header_flags;
    assign packet_id       = head.packet_id;
    assign scrambling      = head.scrambling;
    assign adapt_control   = head.adapt_control;
    assign continuity      = head.continuity;
    assign adapt_flags     = head.adapt_flags;
    assign clock_reference = head.clock_reference;
    assign payload_length  = head.payload_length;
    assign status          = head.status;

endmodule

/* rtl/tsph_result_queue.sv */
// Small flip-flop queue holding parser results until the output side takes them.
// Accepts up to two entries per cycle; depends on tsph_pkg.
module tsph_result_queue #(
    parameter int DEPTH = tsph_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tsph_pkg::push_t   push,
    output logic              room_for_two,
    output logic              out_valid,
    input  logic              out_ready,
    output tsph_pkg::result_t head
);

    // DEPTH must be a power of two so that the pointers wrap on their own.
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tsph_pkg::result_t entry_reg [DEPTH];
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pop;
    logic [CNT_W-1:0]  count_after_pop;

    assign out_valid = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign pop       = out_valid & out_ready;

    // A slot freed by this cycle's pop is usable by this cycle's push.
    assign count_after_pop = count_reg - CNT_W'(pop);
    assign room_for_two    = (count_after_pop <= CNT_W'(DEPTH - 2));

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        count_next  = count_after_pop + CNT_W'(push.count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= push.second;
        end
    end

endmodule
